[sv/biquad_cascade_filter_defines.svh]
// assertion macros for the biquad cascade filter
`ifndef BIQUAD_CASCADE_FILTER_DEFINES_SVH
`define BIQUAD_CASCADE_FILTER_DEFINES_SVH

// property holds at every clock edge out of reset
`define BCF_ASSERT_HOLD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define BCF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[sv/bcf_pkg.sv]
`timescale 1ns / 1ps
package bcf_pkg;

  localparam int MAX_STAGES      = 4;
  localparam int COEFS_PER_STAGE = 5;
  localparam int CUR_W   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int STAGE_W = 3;
  localparam int CMP_W   = (CUR_W + 1 > STAGE_W) ? CUR_W + 1 : STAGE_W;
  localparam int IDX_W    = 5;
  localparam int COEF_W   = 32;
  localparam int SAMPLE_W = 16;
  localparam int VAL_W    = 32;
  localparam int DLY_W    = 48;
  localparam int PROD_W   = 64;
  localparam int FRAC_W   = 28;
  localparam int RQ_W     = PROD_W - FRAC_W;
  localparam int ACC_W    = 50;
  localparam int DC_W     = 35;
  localparam int QMAG_W   = DC_W - 1 + FRAC_W;
  localparam int REM_W    = DC_W;
  localparam int STEP_W   = 3;
  localparam int POS_W    = 3;

  localparam logic [STEP_W-1:0] LAST_STEP = 3'd5;

  // opcodes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_PRESET = 2'd2;
  localparam logic [1:0] OP_FILTER = 2'd3;

  // coefficient positions within a stage
  localparam logic [POS_W-1:0] POS_B0 = 3'd0;
  localparam logic [POS_W-1:0] POS_B1 = 3'd1;
  localparam logic [POS_W-1:0] POS_B2 = 3'd2;
  localparam logic [POS_W-1:0] POS_A1 = 3'd3;
  localparam logic [POS_W-1:0] POS_A2 = 3'd4;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic              en;
    logic              preset;
    logic              clear;
    logic [STEP_W-1:0] step;
  } cell_ctrl_t;

  typedef struct packed {
    logic             we;
    logic [POS_W-1:0] pos;
    coef_t            value;
  } coef_wr_t;

  typedef struct packed {
    logic signed [DC_W-1:0] num;
    logic signed [DC_W-1:0] den;
  } dc_terms_t;

  // product at 2^-28 rounded half up back to the value scale
  function automatic logic signed [RQ_W-1:0] round_q28(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + (PROD_W'(1) << (FRAC_W - 1));
    return s[PROD_W-1:FRAC_W];
  endfunction

  function automatic logic ovf32(input logic signed [ACC_W-1:0] v);
    return !((&v[ACC_W-1:VAL_W-1]) || !(|v[ACC_W-1:VAL_W-1]));
  endfunction

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (ovf32(v)) begin
      return v[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end
    return v[VAL_W-1:0];
  endfunction

  function automatic logic ovf48(input logic signed [ACC_W-1:0] v);
    return !((&v[ACC_W-1:DLY_W-1]) || !(|v[ACC_W-1:DLY_W-1]));
  endfunction

  function automatic logic signed [DLY_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    if (ovf48(v)) begin
      return v[ACC_W-1] ? {1'b1, {(DLY_W-1){1'b0}}} : {1'b0, {(DLY_W-1){1'b1}}};
    end
    return v[DLY_W-1:0];
  endfunction

endpackage

[sv/biquad_cascade_filter.sv]
`timescale 1ns / 1ps
// Cascade of up to four transposed direct form II biquads, one cell per stage
// with its own 32x32 multiplier; the cells run one after another. A filter
// transfer (opcode 3) runs the six steps of each active cell's multiply
// sequence. A preset (opcode 2) adds a dc-gain division per stage, done by
// one shared bit-serial divider. Coefficient loads and delay clears are
// applied directly from the accepted transfer. A new item is taken while a
// finished result still waits on the output. Coefficient slots are undefined
// until loaded; every slot of the active stages must be loaded before
// filtering or presetting. Writing stage_count (1 to 4) also clears all
// delays.
module biquad_cascade_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // coeff_index[4:0], coeff_value[36:5], sample[52:37]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // filtered[15:0]
  output logic [0:0]  out_tuser,  // saturated[0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bcf_pkg::*;

`include "biquad_cascade_filter_defines.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;
  localparam int IDXC_W = IDX_W + 4;

  logic [1:0]          state_r;
  logic [CUR_W-1:0]    cur_r;
  logic [STEP_W-1:0]   step_r;
  logic                preset_r, sat_r, div_go_r;
  logic [STAGE_W-1:0]  stage_count_r;
  logic signed [VAL_W-1:0] x_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_data_r;
  logic                out_sat_r;

  logic [1:0]           op;
  logic [IDX_W-1:0]     idx;
  coef_t                cval;
  logic signed [SAMPLE_W-1:0] smp;
  logic                 in_acc, out_acc, cfg_wr, cfg_ok, clr, last_stage;
  logic [MAX_STAGES-1:0] cell_en, clip_vec;
  logic signed [VAL_W-1:0] y_vec [MAX_STAGES];
  dc_terms_t            dc_vec [MAX_STAGES];
  logic                 div_done;
  logic signed [VAL_W-1:0] div_gain;
  logic signed [VAL_W:0]   rnd_sum;
  logic signed [SAMPLE_W:0] rnd_q;
  logic                 rnd_ovf;
  logic [SAMPLE_W-1:0]  rnd_out;

  // unpack the input transfer
  assign op   = in_tuser;
  assign idx  = in_tdata[IDX_W-1:0];
  assign cval = in_tdata[IDX_W+COEF_W-1:IDX_W];
  assign smp  = in_tdata[IDX_W+COEF_W+SAMPLE_W-1:IDX_W+COEF_W];

  assign in_tready = state_r == ST_IDLE;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_valid_r && out_tready;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2];
  assign cfg_ok = (cfg_pwdata[STAGE_W-1:0] != '0) &&
                  (CMP_W'(cfg_pwdata[STAGE_W-1:0]) <= CMP_W'(MAX_STAGES));
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : 32'(stage_count_r);

  assign clr = (in_acc && op == OP_CLEAR) || (cfg_wr && cfg_ok);
  assign last_stage = (CMP_W'(cur_r) + CMP_W'(1)) == CMP_W'(stage_count_r);

  // row of stage cells
  genvar i;
  generate
    for (i = 0; i < MAX_STAGES; i++) begin : g_cell
      localparam int BASE = i * COEFS_PER_STAGE;
      cell_ctrl_t ctrl;
      coef_wr_t   wr;
      logic signed [VAL_W-1:0] v_in;

      assign cell_en[i]  = (state_r == ST_RUN) && (cur_r == CUR_W'(i));
      assign ctrl.en     = cell_en[i];
      assign ctrl.preset = preset_r;
      assign ctrl.clear  = clr;
      assign ctrl.step   = step_r;
      assign wr.we    = in_acc && (op == OP_LOAD) &&
                        (IDXC_W'(idx) >= IDXC_W'(BASE)) &&
                        (IDXC_W'(idx) < IDXC_W'(BASE + COEFS_PER_STAGE));
      assign wr.pos   = POS_W'(IDXC_W'(idx) - IDXC_W'(BASE));
      assign wr.value = cval;

      if (i == 0) begin : g_first
        assign v_in = x_r;
      end else begin : g_next
        assign v_in = y_vec[i-1];
      end

      bcf_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .wr    (wr),
        .v_in  (v_in),
        .gain  (div_gain),
        .y_out (y_vec[i]),
        .clip  (clip_vec[i]),
        .dc    (dc_vec[i])
      );
    end
  endgenerate

  // shared dc gain divider
  bcf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .dc    (dc_vec[cur_r]),
    .done  (div_done),
    .gain  (div_gain)
  );

  // final rounding to a 16-bit sample
  assign rnd_sum = (VAL_W+1)'(y_vec[cur_r]) + (VAL_W+1)'(1 <<< (SAMPLE_W - 1));
  assign rnd_q   = rnd_sum[VAL_W:SAMPLE_W];
  assign rnd_ovf = rnd_q[SAMPLE_W] != rnd_q[SAMPLE_W-1];
  assign rnd_out = rnd_ovf ? (rnd_q[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                              : {1'b0, {(SAMPLE_W-1){1'b1}}})
                           : rnd_q[SAMPLE_W-1:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cur_r         <= '0;
      step_r        <= '0;
      preset_r      <= 1'b0;
      div_go_r      <= 1'b0;
      stage_count_r <= STAGE_W'(1);
      out_valid_r   <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr && cfg_ok) begin
        stage_count_r <= cfg_pwdata[STAGE_W-1:0];
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && op == OP_PRESET) begin
            state_r  <= ST_DIV;
            cur_r    <= '0;
            preset_r <= 1'b1;
            div_go_r <= 1'b1;
          end else if (in_acc && op == OP_FILTER) begin
            state_r  <= ST_RUN;
            cur_r    <= '0;
            step_r   <= '0;
            preset_r <= 1'b0;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_RUN;
            step_r  <= '0;
          end
        end
        ST_RUN: begin
          if (step_r == LAST_STEP) begin
            step_r <= '0;
            if (last_stage) begin
              state_r <= preset_r ? ST_IDLE : ST_FIN;
            end else begin
              cur_r <= cur_r + CUR_W'(1);
              if (preset_r) begin
                state_r  <= ST_DIV;
                div_go_r <= 1'b1;
              end
            end
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // sample and flag payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r   <= VAL_W'(smp) <<< SAMPLE_W;
      sat_r <= 1'b0;
    end else if (state_r == ST_RUN && !preset_r && (|clip_vec)) begin
      sat_r <= 1'b1;
    end
    if (state_r == ST_FIN && (!out_valid_r || out_tready)) begin
      out_data_r <= rnd_out;
      out_sat_r  <= sat_r || rnd_ovf;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_sat_r;

  // checks
  `BCF_ASSERT_HOLD(a_one_cell_active, $onehot0(cell_en), "more than one stage cell active")
  `BCF_ASSERT_IMPLIES(a_div_done_in_div, div_done, state_r == ST_DIV, "divider finished outside preset wait")
  `BCF_ASSERT_IMPLIES(a_stage_in_range, state_r != ST_IDLE, CMP_W'(cur_r) < CMP_W'(stage_count_r), "stage pointer beyond stage count")

endmodule

[sv/bcf_div.sv]
`timescale 1ns / 1ps
module bcf_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  bcf_pkg::dc_terms_t                 dc,
  output logic                               done,
  output logic signed [bcf_pkg::VAL_W-1:0]   gain
);
  import bcf_pkg::*;

  localparam int CNT_W = $clog2(QMAG_W);

  logic              busy_r, fin_r, done_r, neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [QMAG_W-1:0] q_r;
  logic [DC_W-2:0]   dvs_r;
  logic signed [VAL_W-1:0] gain_r;

  logic [DC_W-1:0]  num_abs, den_abs;
  logic [REM_W-1:0] rem_sh, rem_nxt;
  logic             ge;
  logic             mag_big_pos, mag_big_neg;

  // magnitudes of the dc terms
  assign num_abs = dc.num[DC_W-1] ? DC_W'(-dc.num) : DC_W'(dc.num);
  assign den_abs = dc.den[DC_W-1] ? DC_W'(-dc.den) : DC_W'(dc.den);

  // one restoring step per cycle
  assign rem_sh  = {rem_r[REM_W-2:0], q_r[QMAG_W-1]};
  assign ge      = rem_sh >= REM_W'(dvs_r);
  assign rem_nxt = ge ? rem_sh - REM_W'(dvs_r) : rem_sh;

  // quotient range checks for saturation
  assign mag_big_pos = |q_r[QMAG_W-1:VAL_W-1];
  assign mag_big_neg = (|q_r[QMAG_W-1:VAL_W]) || (q_r[VAL_W-1] && (|q_r[VAL_W-2:0]));

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (start) begin
        if (dc.den == '0) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QMAG_W - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dc.num[DC_W-1] ^ dc.den[DC_W-1];
      rem_r <= '0;
      q_r   <= {num_abs[DC_W-2:0], {FRAC_W{1'b0}}};
      dvs_r <= den_abs[DC_W-2:0];
      if (dc.num[DC_W-1]) begin
        gain_r <= {1'b1, {(VAL_W-1){1'b0}}};
      end else if (dc.num != '0) begin
        gain_r <= {1'b0, {(VAL_W-1){1'b1}}};
      end else begin
        gain_r <= '0;
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[QMAG_W-2:0], ge};
    end else if (fin_r) begin
      if (neg_r) begin
        gain_r <= mag_big_neg ? {1'b1, {(VAL_W-1){1'b0}}} : VAL_W'(-q_r[VAL_W-1:0]);
      end else begin
        gain_r <= mag_big_pos ? {1'b0, {(VAL_W-1){1'b1}}} : q_r[VAL_W-1:0];
      end
    end
  end

  assign done = done_r;
  assign gain = gain_r;

endmodule

[sv/bcf_cell.sv]
`timescale 1ns / 1ps
module bcf_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bcf_pkg::cell_ctrl_t               ctrl,
  input  bcf_pkg::coef_wr_t                 wr,
  input  logic signed [bcf_pkg::VAL_W-1:0]  v_in,
  input  logic signed [bcf_pkg::VAL_W-1:0]  gain,
  output logic signed [bcf_pkg::VAL_W-1:0]  y_out,
  output logic                              clip,
  output bcf_pkg::dc_terms_t                dc
);
  import bcf_pkg::*;

  coef_t c_r [COEFS_PER_STAGE];
  logic signed [DLY_W-1:0]  d1_r, d2_r;
  logic signed [VAL_W-1:0]  y_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [COEF_W-1:0] mul_a;
  logic signed [VAL_W-1:0]  mul_b;
  logic signed [ACC_W-1:0]  rq_x, sum_y, sum_a, acc_nxt;
  logic                     last_step;

  // coefficient slots
  always_ff @(posedge clk) begin
    if (wr.we) begin
      c_r[wr.pos] <= wr.value;
    end
  end

  // dc gain terms for the preset divider
  assign dc.num = DC_W'(c_r[POS_B0]) + DC_W'(c_r[POS_B1]) + DC_W'(c_r[POS_B2]);
  assign dc.den = (DC_W'(1) << FRAC_W) - DC_W'(c_r[POS_A1]) - DC_W'(c_r[POS_A2]);

  // multiplier operands per step
  always_comb begin
    mul_a = c_r[POS_B0];
    mul_b = v_in;
    if (ctrl.preset) begin
      case (ctrl.step)
        3'd0: mul_a = gain;
        3'd1: mul_a = c_r[POS_B2];
        3'd2: begin
          mul_a = c_r[POS_A2];
          mul_b = y_r;
        end
        3'd3: mul_a = c_r[POS_B1];
        3'd4: begin
          mul_a = c_r[POS_A1];
          mul_b = y_r;
        end
        default: mul_a = c_r[POS_B0];
      endcase
    end else begin
      case (ctrl.step)
        3'd0: mul_a = c_r[POS_B0];
        3'd1: mul_a = c_r[POS_B1];
        3'd2: begin
          mul_a = c_r[POS_A1];
          mul_b = y_r;
        end
        3'd3: mul_a = c_r[POS_B2];
        3'd4: begin
          mul_a = c_r[POS_A2];
          mul_b = y_r;
        end
        default: mul_a = c_r[POS_B0];
      endcase
    end
  end

  // adders behind the product register
  assign last_step = ctrl.step == LAST_STEP;
  assign rq_x  = ACC_W'(round_q28(prod_r));
  assign sum_y = rq_x + (ctrl.preset ? ACC_W'(0) : ACC_W'(d1_r));
  assign sum_a = acc_r + rq_x + ((ctrl.preset && last_step) ? ACC_W'(d2_r) : ACC_W'(0));
  assign acc_nxt = (ctrl.step == 3'd2 && !ctrl.preset) ? rq_x + ACC_W'(d2_r) : rq_x;

  // delay state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= '0;
      d2_r <= '0;
    end else if (ctrl.clear) begin
      d1_r <= '0;
      d2_r <= '0;
    end else if (ctrl.en) begin
      case (ctrl.step)
        3'd3: begin
          if (ctrl.preset) begin
            d2_r <= sat48(sum_a);
          end else begin
            d1_r <= sat48(sum_a);
          end
        end
        3'd5: begin
          if (ctrl.preset) begin
            d1_r <= sat48(sum_a);
          end else begin
            d2_r <= sat48(sum_a);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // multiply and accumulate
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      prod_r <= mul_a * mul_b;
      case (ctrl.step)
        3'd1: y_r <= sat32(sum_y);
        3'd2: acc_r <= acc_nxt;
        3'd4: acc_r <= acc_nxt;
        default: begin
        end
      endcase
    end
  end

  // clip events while filtering
  assign clip = ctrl.en && !ctrl.preset &&
                ((ctrl.step == 3'd1 && ovf32(sum_y)) ||
                 ((ctrl.step == 3'd3 || last_step) && ovf48(sum_a)));

  assign y_out = y_r;

endmodule

[test/biquad_cascade_filter_checker.sv]
`timescale 1ns / 1ps
// watches the sample and result channels and the register port, keeps its own
// model of the cascade and checks every result transfer against it
module biquad_cascade_filter_checker #(
  parameter logic [2:0] STAGE_REG_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,   // coeff_index[4:0], coeff_value[36:5], sample[52:37]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // filtered[15:0]
  input  logic [0:0]  out_tuser,  // saturated[0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          mismatches,
  output int          pending,
  output int          results_seen
);
  import bcf_pkg::*;

  localparam int SLOTS = MAX_STAGES * COEFS_PER_STAGE;
  localparam longint V32_MAX = 64'sd2147483647;
  localparam longint V32_MIN = -64'sd2147483648;
  localparam longint D48_MAX = (64'sd1 <<< 47) - 1;
  localparam longint D48_MIN = -(64'sd1 <<< 47);
  localparam longint Q28_ONE = 64'sd1 <<< 28;

  typedef struct packed {
    logic signed [15:0] filtered;
    logic               saturated;
  } filter_result_t;

  filter_result_t expected_results[$];

  longint coefs[SLOTS];
  longint z1[MAX_STAGES];
  longint z2[MAX_STAGES];
  int     active_stages;
  bit     clip_flag;

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v > hi) begin
      clip_flag = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clip_flag = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // q3.28 coefficient times value, rounded half up to the value scale
  function automatic longint qmul(longint c, longint v);
    return (c * v + (64'sd1 <<< 27)) >>> 28;
  endfunction

  function automatic void zero_delays();
    for (int i = 0; i < MAX_STAGES; i++) begin
      z1[i] = 0;
      z2[i] = 0;
    end
  endfunction

  function automatic void steady_preset(longint v);
    longint num, den, gain, y, nd2;
    int b;
    for (int i = 0; i < active_stages; i++) begin
      b = i * COEFS_PER_STAGE;
      num = coefs[b] + coefs[b+1] + coefs[b+2];
      den = Q28_ONE - coefs[b+3] - coefs[b+4];
      if (den == 0) gain = (num > 0) ? V32_MAX : ((num < 0) ? V32_MIN : 0);
      else gain = clamp((num * Q28_ONE) / den, V32_MIN, V32_MAX);
      y = clamp(qmul(gain, v), V32_MIN, V32_MAX);
      nd2 = clamp(qmul(coefs[b+2], v) + qmul(coefs[b+4], y), D48_MIN, D48_MAX);
      z1[i] = clamp(qmul(coefs[b+1], v) + qmul(coefs[b+3], y) + nd2, D48_MIN, D48_MAX);
      z2[i] = nd2;
      v = y;
    end
  endfunction

  function automatic filter_result_t run_cascade(longint v);
    filter_result_t r;
    longint y, n1, n2;
    int b;
    clip_flag = 1'b0;
    for (int i = 0; i < active_stages; i++) begin
      b = i * COEFS_PER_STAGE;
      y  = clamp(qmul(coefs[b], v) + z1[i], V32_MIN, V32_MAX);
      n1 = clamp(qmul(coefs[b+1], v) + qmul(coefs[b+3], y) + z2[i], D48_MIN, D48_MAX);
      n2 = clamp(qmul(coefs[b+2], v) + qmul(coefs[b+4], y), D48_MIN, D48_MAX);
      z1[i] = n1;
      z2[i] = n2;
      v = y;
    end
    r.filtered  = 16'(clamp((v + 32768) >>> 16, -32768, 32767));
    r.saturated = clip_flag;
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    logic [4:0] idx;
    longint     smp;
    logic [2:0] n;
    filter_result_t exp_r;
    if (!rst_n) begin
      expected_results.delete();
      for (int i = 0; i < SLOTS; i++) coefs[i] = 0;
      zero_delays();
      active_stages = 1;
      mismatches   <= 0;
      results_seen <= 0;
    end else begin
      // register write: stage count, out-of-range values are ignored
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == STAGE_REG_ADDR) begin
        n = cfg_pwdata[2:0];
        if (n >= 1 && n <= MAX_STAGES) begin
          active_stages = n;
          zero_delays();
        end
      end
      // result transfer
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("[%0t] result with none expected: %h/%b",
                                        $realtime, out_tdata, out_tuser);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_tdata !== exp_r.filtered || out_tuser[0] !== exp_r.saturated) begin
            if (mismatches < 10)
              $display("[%0t] filtered exp %0d got %0d, saturated exp %b got %b",
                       $realtime, exp_r.filtered, $signed(out_tdata),
                       exp_r.saturated, out_tuser[0]);
            mismatches <= mismatches + 1;
          end
        end
      end
      // sample channel transfer
      if (in_tvalid && in_tready) begin
        idx = in_tdata[4:0];
        smp = longint'($signed(in_tdata[52:37])) * 65536;
        case (in_tuser)
          OP_LOAD: if (idx < SLOTS) coefs[idx] = longint'($signed(in_tdata[36:5]));
          OP_CLEAR: zero_delays();
          OP_PRESET: steady_preset(smp);
          OP_FILTER: expected_results.push_back(run_cascade(smp));
          default: ;
        endcase
      end
    end
  end
endmodule

[test/biquad_cascade_filter_tb.sv]
`timescale 1ns / 1ps
module biquad_cascade_filter_tb;
  import bcf_pkg::*;

  localparam logic [2:0] STAGE_REG_ADDR = 3'd0;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_PER_PHASE = 92;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // coeff_index[4:0], coeff_value[36:5], sample[52:37]
  logic [1:0]  in_tuser;   // opcode[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // filtered[15:0]
  logic [0:0]  out_tuser;  // saturated[0]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatches, pending, results_seen;
  int send_idle_pct, recv_idle_pct;
  int hold_left;
  logic hold_kick;
  int cycles;

  biquad_cascade_filter u_top (.*);

  biquad_cascade_filter_checker #(.STAGE_REG_ADDR(STAGE_REG_ADDR)) u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .mismatches, .pending, .results_seen
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) hold_left <= 0;
    else if (hold_kick) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, logic [4:0] idx, logic [31:0] val,
                           logic [15:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, smp, val, idx};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_stages(logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= STAGE_REG_ADDR;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every result, then for a preset that may still be running
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coef(logic [4:0] idx);
    if ($urandom_range(99) < 12) return $urandom;
    if (idx % COEFS_PER_STAGE >= POS_A1) return 32'($urandom_range(2 * 2**26) - 2**26);
    return 32'($urandom_range(2 * 2**27) - 2**27);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_item();
    int r;
    logic [4:0] idx;
    r = $urandom_range(99);
    if (r < 15) begin
      idx = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 20)) : 5'($urandom_range(19));
      send_item(OP_LOAD, idx, pick_coef(idx), 16'($urandom));
    end else if (r < 20) begin
      send_item(OP_CLEAR, 5'($urandom), $urandom, 16'($urandom));
    end else if (r < 32) begin
      send_item(OP_PRESET, 5'($urandom), $urandom, pick_sample());
    end else begin
      send_item(OP_FILTER, 5'($urandom), $urandom, pick_sample());
    end
  endtask

  logic [31:0] stage_plan [8] = '{32'd4, 32'd2, 32'd0, 32'd3, 32'd5, 32'd1, 32'hffff_fff7, 32'd4};

  initial begin
    logic [4:0] i;
    rst_n = 1'b0;
    cycles = 0;
    hold_kick = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_LOAD;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fill every slot, then extremes, preset, zero denominator
    for (int k = 0; k < MAX_STAGES * COEFS_PER_STAGE; k++) begin
      i = 5'(k);
      send_item(OP_LOAD, i, pick_coef(i), 16'h0);
    end
    send_item(OP_FILTER, 5'd0, 32'h0, 16'h7fff);
    send_item(OP_FILTER, 5'd0, 32'h0, 16'h8000);
    send_item(OP_CLEAR, 5'd0, 32'h0, 16'h0);
    send_item(OP_PRESET, 5'd0, 32'h0, 16'h7fff);
    send_item(OP_FILTER, 5'd0, 32'h0, 16'h7fff);
    // a1 of one with a2 of zero: dc gain denominator vanishes
    send_item(OP_LOAD, {2'b00, POS_A1}, 32'h1000_0000, 16'h0);
    send_item(OP_LOAD, {2'b00, POS_A2}, 32'h0, 16'h0);
    send_item(OP_PRESET, 5'd0, 32'h0, 16'h8000);
    send_item(OP_FILTER, 5'd0, 32'h0, 16'h8000);
    send_item(OP_LOAD, 5'd31, 32'h7fff_ffff, 16'h0);
    send_item(OP_LOAD, 5'd3, 32'h8000_0000, 16'hffff);

    for (int p = 0; p < 8; p++) begin
      settle();
      write_stages(stage_plan[p]);
      if (p < 3) begin
        send_idle_pct = 32;
        recv_idle_pct = 49;
      end else if (p < 6) begin
        send_idle_pct = 49;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 1 || p == 6) begin
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
      end
      repeat (RAND_PER_PHASE) random_item();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d checked results over stage counts 1 to 4,", results_seen);
    $display("with ignored register values and slots, presets and long output stalls");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
